// ===== rtl/core/mwtg_pkg.sv =====
`timescale 1ns / 1ps

package mwtg_pkg;

    // Default geometry of the accumulators and the sine angle resolution.
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_POSITION_BITS   = 16;
    localparam int DEF_SINE_TABLE_BITS = 10;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_LEN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RISE_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FALL_LENGTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN          = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_BITS   = 3'd6;

    // Waveform modes.
    localparam logic [1:0] MODE_SINE  = 2'd0;
    localparam logic [1:0] MODE_PULSE = 2'd1;
    localparam logic [1:0] MODE_RAMP  = 2'd2;

    // Register reset values.
    localparam logic [1:0]  RST_WAVEFORM_MODE = MODE_SINE;
    localparam logic [31:0] RST_PHASE_STEP    = 32'd42949673;
    localparam logic [15:0] RST_PERIOD_LEN    = 16'd100;
    localparam logic [23:0] RST_RISE_LENGTH   = 24'd12800;
    localparam logic [23:0] RST_FALL_LENGTH   = 24'd12800;
    localparam logic [15:0] RST_GAIN          = 16'd4096;
    localparam logic [4:0]  RST_SAMPLE_BITS   = 5'd16;

    // Iterative unit: sixteen CORDIC rotations, seventeen quotient bits.
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_COUNT   = 17;
    localparam int STEP_W       = 5;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [CORDIC_W-1:0] atan_turn(input logic [3:0] idx);
        logic [CORDIC_W-1:0] v;
        case (idx)
            4'd0:    v = 34'd536870912;
            4'd1:    v = 34'd316933406;
            4'd2:    v = 34'd167458907;
            4'd3:    v = 34'd85004756;
            4'd4:    v = 34'd42667331;
            4'd5:    v = 34'd21354465;
            4'd6:    v = 34'd10679838;
            4'd7:    v = 34'd5340245;
            4'd8:    v = 34'd2670163;
            4'd9:    v = 34'd1335087;
            4'd10:   v = 34'd667544;
            4'd11:   v = 34'd333772;
            4'd12:   v = 34'd166886;
            4'd13:   v = 34'd83443;
            4'd14:   v = 34'd41722;
            default: v = 34'd20861;
        endcase
        return v;
    endfunction

    // Configuration register set.
    typedef struct packed {
        logic [1:0]  waveform_mode;
        logic [31:0] phase_step;
        logic [15:0] period_len;
        logic [23:0] rise_length_q8;
        logic [23:0] fall_length_q8;
        logic [15:0] gain_q12;
        logic [4:0]  sample_bits;
    } t_cfg;

    // One input tick.
    typedef struct packed {
        logic restart;
        logic last_of_run;
    } t_in_item;

    // One output sample.
    typedef struct packed {
        logic signed [23:0] sample;
        logic               clipped;
        logic               last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              start;
        logic              load;
        logic              prep;
        logic              iter;
        logic              raw;
        logic              mul;
        logic              scale;
        logic              finish;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

endpackage

// ===== rtl/core/mwtg_cfg.sv =====
`timescale 1ns / 1ps

module mwtg_cfg
    import mwtg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    // Register bank; writes to unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waveform_mode  <= RST_WAVEFORM_MODE;
            r_cfg.phase_step     <= RST_PHASE_STEP;
            r_cfg.period_len     <= RST_PERIOD_LEN;
            r_cfg.rise_length_q8 <= RST_RISE_LENGTH;
            r_cfg.fall_length_q8 <= RST_FALL_LENGTH;
            r_cfg.gain_q12       <= RST_GAIN;
            r_cfg.sample_bits    <= RST_SAMPLE_BITS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WAVEFORM_MODE: r_cfg.waveform_mode  <= i_cfg_data[1:0];
                REG_PHASE_STEP:    r_cfg.phase_step     <= i_cfg_data[31:0];
                REG_PERIOD_LEN:    r_cfg.period_len     <= i_cfg_data[15:0];
                REG_RISE_LENGTH:   r_cfg.rise_length_q8 <= i_cfg_data[23:0];
                REG_FALL_LENGTH:   r_cfg.fall_length_q8 <= i_cfg_data[23:0];
                REG_GAIN:          r_cfg.gain_q12       <= i_cfg_data[15:0];
                REG_SAMPLE_BITS:   r_cfg.sample_bits    <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/mwtg_ctrl.sv =====
`timescale 1ns / 1ps

module mwtg_ctrl
    import mwtg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_ITER  = 3'd3;
    localparam logic [2:0] S_RAW   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ITER_COUNT - 1);

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_in_fire;
    logic              w_commit;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in_valid && o_in_ready;
    // The finished sample moves into the output register once it is free.
    assign w_commit   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Sequencer for one tick.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                n_state = S_ITER;
                n_step  = '0;
            end
            S_ITER: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_RAW;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_RAW: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag: set on commit, cleared when the transaction completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath commands.
    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = w_in_fire;
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.prep   = (r_state == S_PREP);
        o_cmd.iter   = (r_state == S_ITER);
        o_cmd.raw    = (r_state == S_RAW);
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.scale  = (r_state == S_SCALE);
        o_cmd.finish = w_commit;
        o_cmd.step   = r_step;
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/mwtg_datapath.sv =====
`timescale 1ns / 1ps

module mwtg_datapath
    import mwtg_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int POSITION_BITS   = DEF_POSITION_BITS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_data,
    output t_out_item o_out_data
);

    localparam int NUM_W     = POSITION_BITS + 8;
    localparam int CMP_W     = (NUM_W > 25) ? NUM_W : 25;
    localparam int PSTEP_W   = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int PCMP_W    = (POSITION_BITS > 16) ? POSITION_BITS : 16;
    localparam int PROD1_W   = 33;
    localparam int PROD2_W   = 57;
    localparam int SCALED_W  = 30;
    localparam int SCALE_SHR = 27;

    // Tick state.
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [PHASE_BITS-1:0]    r_phase, n_phase;
    logic                     r_last;

    // Ramp division operands and flags.
    logic [NUM_W-1:0] r_num;
    logic [23:0]      r_den;
    logic [23:0]      r_rem;
    logic [16:0]      r_quo;
    logic             r_asc;
    logic             r_below;
    logic             r_zero;
    logic             r_ovf;

    // CORDIC vector and residual angle.
    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;

    // Scaling pipeline.
    logic                  r_neg;
    logic [16:0]           r_mag;
    logic [PROD1_W-1:0]    r_prod1;
    logic [SCALED_W-1:0]   r_scaled;
    logic [24:0]           r_limit;
    t_out_item             r_out;

    // Combinational helpers.
    logic [NUM_W-1:0]           w_p;
    logic                       w_below;
    logic [31:0]                w_angle, w_fold;
    logic                       w_bit;
    logic [24:0]                w_rem2;
    logic                       w_fit;
    logic signed [CORDIC_W-1:0] w_dx, w_dy, w_atan;
    logic signed [CORDIC_W-1:0] w_ysum, w_yr;
    logic signed [17:0]         w_sine, w_raw;
    logic [16:0]                w_qc;
    logic [4:0]                 w_bits, w_shift;
    logic [PROD2_W-1:0]         w_prod2;
    logic                       w_clip;
    logic [24:0]                w_mag_sat;
    logic [24:0]                w_signed_mag;
    logic [PSTEP_W-1:0]         w_step_ext;
    logic [POSITION_BITS-1:0]   w_pos_inc;

    assign w_p     = {r_pos, 8'h00};
    assign w_below = CMP_W'(w_p) < CMP_W'(i_cfg.rise_length_q8);

    // Sine angle: top bits of the phase, folded into the right half plane.
    always_comb begin
        w_angle = {r_phase[PHASE_BITS-1 -: SINE_TABLE_BITS], {(32 - SINE_TABLE_BITS){1'b0}}};
        if ((w_angle - 32'h4000_0000) < 32'h8000_0000) begin
            w_fold = 32'h8000_0000 - w_angle;
        end else begin
            w_fold = w_angle;
        end
    end

    // One restoring division step; the low numerator bit enters on the first step only.
    assign w_bit  = (i_cmd.step == '0) ? r_num[0] : 1'b0;
    assign w_rem2 = {r_rem, w_bit};
    assign w_fit  = (w_rem2 >= {1'b0, r_den});

    // One CORDIC rotation step.
    assign w_dx   = r_y >>> i_cmd.step[3:0];
    assign w_dy   = r_x >>> i_cmd.step[3:0];
    assign w_atan = $signed(atan_turn(i_cmd.step[3:0]));

    // Sine result rounded from Q2.30 to Q1.15 and clamped.
    always_comb begin
        w_ysum = r_y + 34'sd16384;
        w_yr   = w_ysum >>> 15;
        if (w_yr > 34'sd32768) begin
            w_sine = 18'sd32768;
        end else if (w_yr < -34'sd32768) begin
            w_sine = -18'sd32768;
        end else begin
            w_sine = 18'(w_yr);
        end
    end

    // Raw value in Q1.15 for the selected waveform.
    always_comb begin
        w_qc = (r_ovf || (r_quo > 17'd65536)) ? 17'd65536 : r_quo;
        unique case (i_cfg.waveform_mode)
            MODE_SINE: begin
                w_raw = w_sine;
            end
            MODE_PULSE: begin
                w_raw = r_below ? 18'sd32768 : -18'sd32768;
            end
            MODE_RAMP: begin
                if (r_zero) begin
                    w_raw = '0;
                end else if (r_asc) begin
                    w_raw = $signed({1'b0, w_qc}) - 18'sd32768;
                end else begin
                    w_raw = 18'sd32768 - $signed({1'b0, w_qc});
                end
            end
            default: begin
                w_raw = '0;
            end
        endcase
    end

    // Output width clamped to 8..24 bits; full scale is 2^(bits-1)-1.
    always_comb begin
        if (i_cfg.sample_bits < 5'd8) begin
            w_bits = 5'd8;
        end else if (i_cfg.sample_bits > 5'd24) begin
            w_bits = 5'd24;
        end else begin
            w_bits = i_cfg.sample_bits;
        end
        w_shift = w_bits - 5'd1;
        w_prod2 = (PROD2_W'(r_prod1) << w_shift) - PROD2_W'(r_prod1);
    end

    // Saturation against the bound for the sign of the sample.
    assign w_clip       = SCALED_W'(r_limit) < r_scaled;
    assign w_mag_sat    = w_clip ? r_limit : r_scaled[24:0];
    assign w_signed_mag = r_neg ? (25'd0 - w_mag_sat) : w_mag_sat;

    // Position and phase advance after the sample.
    always_comb begin
        w_step_ext = PSTEP_W'(i_cfg.phase_step);
        n_phase    = r_phase + w_step_ext[PHASE_BITS-1:0];
        w_pos_inc  = r_pos + 1'b1;
        if (PCMP_W'(w_pos_inc) >= PCMP_W'(i_cfg.period_len)) begin
            n_pos = '0;
        end else begin
            n_pos = w_pos_inc;
        end
    end

    // Tick state: cleared by restart at the start of a tick, advanced at its end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= '0;
        end else if (i_cmd.start && i_in_data.restart) begin
            r_pos   <= '0;
            r_phase <= '0;
        end else if (i_cmd.finish) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_last <= i_in_data.last_of_run;
        end

        // Operand set-up for both the divider and the CORDIC.
        if (i_cmd.load) begin
            r_asc   <= (i_cfg.fall_length_q8 == '0) || w_below;
            r_below <= w_below;
            r_zero  <= (i_cfg.rise_length_q8 == '0) && (i_cfg.fall_length_q8 == '0);
            if ((i_cfg.fall_length_q8 == '0) || w_below) begin
                r_num <= w_p;
                r_den <= i_cfg.rise_length_q8;
            end else begin
                r_num <= w_p - NUM_W'(i_cfg.rise_length_q8);
                r_den <= i_cfg.fall_length_q8;
            end
            r_x <= CORDIC_X0;
            r_y <= '0;
            r_z <= {{(CORDIC_W - 32){w_fold[31]}}, w_fold};
        end

        // A quotient of 2^17 or more saturates; otherwise the upper numerator seeds the remainder.
        if (i_cmd.prep) begin
            r_ovf <= CMP_W'(r_num) >= CMP_W'({r_den, 1'b0});
            r_rem <= 24'(r_num >> 1);
            r_quo <= '0;
        end

        if (i_cmd.iter) begin
            if (w_fit) begin
                r_rem <= 24'(w_rem2 - {1'b0, r_den});
            end else begin
                r_rem <= w_rem2[23:0];
            end
            r_quo <= {r_quo[15:0], w_fit};
            if (i_cmd.step < STEP_W'(CORDIC_STEPS)) begin
                if (!r_z[CORDIC_W-1]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_atan;
                end
            end
        end

        // Sign and magnitude of the raw value.
        if (i_cmd.raw) begin
            r_neg <= w_raw[17];
            r_mag <= w_raw[17] ? 17'(-w_raw) : 17'(w_raw);
        end

        if (i_cmd.mul) begin
            r_prod1 <= PROD1_W'(r_mag) * PROD1_W'(i_cfg.gain_q12);
        end

        // Full-scale multiply as shift and subtract, then truncation.
        if (i_cmd.scale) begin
            r_scaled <= SCALED_W'(w_prod2 >> SCALE_SHR);
            r_limit  <= (25'd1 << w_shift) - (r_neg ? 25'd0 : 25'd1);
        end

        if (i_cmd.finish) begin
            r_out.sample  <= w_signed_mag[23:0];
            r_out.clipped <= w_clip;
            r_out.last    <= r_last;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/core/multi_waveform_tone_generator.sv =====
`timescale 1ns / 1ps

// Tone generator producing one signed audio sample per input tick.
// Input channel (i_in_valid / o_in_ready, i_in_data): each transaction is one tick;
// restart zeroes the waveform position and sine phase before the sample is formed,
// and last_of_run is copied into the result as a run marker.
// Output channel (o_out_valid / i_out_ready, o_out_data): one transaction per tick,
// carrying the sample, a saturation flag and the run marker, in input order.
// Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_index; the user
// must write registers only while no tick is in flight; the block does not enforce it.
// Sequence: a tick is accepted only while the generator is idle, so a new tick waits
// until the last result is committed, and can be taken in the cycle it becomes valid.
// Each tick passes set-up, the shared iterative unit, which runs the CORDIC rotations
// and the restoring division of the ramp together, then gain multiply and scaling.
// The finished sample waits in an output register; when the receiver stalls, the next
// tick is still taken and computed, and it waits for that register to empty.
// Reset clears the registers to their defaults, the position and phase to zero and
// the output register to empty.
module multi_waveform_tone_generator
    import mwtg_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int POSITION_BITS   = DEF_POSITION_BITS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data
);

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    // Configuration registers.
    mwtg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Sequencer and handshakes.
    mwtg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Waveform, scaling and output register.
    mwtg_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .POSITION_BITS   (POSITION_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
